// ===== design/ipdu_pkg.sv =====
// ----------------------------------------------------------------------------
// ipdu_pkg
// Types and constants shared by the iSCSI PDU deframer and its channels.
// ----------------------------------------------------------------------------
package ipdu_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CountWidth  = 24;
   localparam int unsigned OpcodeWidth = 6;
   localparam int unsigned TagWidth    = 32;

   // basic header layout
   localparam logic [CountWidth-1:0] HdrLastIdx    = 24'd47;
   localparam logic [CountWidth-1:0] HdrOpcodeIdx  = 24'd0;
   localparam logic [CountWidth-1:0] HdrAhsIdx     = 24'd4;
   localparam logic [CountWidth-1:0] HdrDlenFirst  = 24'd5;
   localparam logic [CountWidth-1:0] HdrDlenLast   = 24'd7;
   localparam logic [CountWidth-1:0] HdrTagFirst   = 24'd16;
   localparam logic [CountWidth-1:0] HdrTagLast    = 24'd19;
   localparam logic [CountWidth-1:0] HdrLength     = 24'd48;

   // segment codes as they appear on the result channel
   typedef enum logic [1:0] {
      SEG_BHS  = 2'd0,
      SEG_AHS  = 2'd1,
      SEG_DATA = 2'd2,
      SEG_PAD  = 2'd3
   } segment_type;

   typedef enum logic [3:0] {
      PH_BHS  = 4'b0001,
      PH_AHS  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_PAD  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0]   byte_out;
      segment_type            segment;
      logic [CountWidth-1:0]  segment_offset;
      logic                   pdu_end;
      logic                   header_done;
      logic [OpcodeWidth-1:0] opcode;
      logic [ByteWidth-1:0]   ahs_words;
      logic [CountWidth-1:0]  data_length;
      logic [TagWidth-1:0]    task_tag;
   } rsp_word_type;

endpackage

// ===== design/ipdu_if.sv =====
// ----------------------------------------------------------------------------
// ipdu channel interfaces
// Valid/ready channels carrying received bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
interface ipdu_req_if;
   logic                                valid;
   logic                                ready;
   logic [ipdu_pkg::ByteWidth-1:0]      data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ipdu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ipdu_pkg::ByteWidth-1:0]      byte_out;
   logic [1:0]                          segment;
   logic [ipdu_pkg::CountWidth-1:0]     segment_offset;
   logic                                pdu_end;
   logic                                header_done;
   logic [ipdu_pkg::OpcodeWidth-1:0]    opcode;
   logic [ipdu_pkg::ByteWidth-1:0]      ahs_words;
   logic [ipdu_pkg::CountWidth-1:0]     data_length;
   logic [ipdu_pkg::TagWidth-1:0]       task_tag;

   modport source (output valid, output byte_out, output segment, output segment_offset,
                   output pdu_end, output header_done, output opcode, output ahs_words,
                   output data_length, output task_tag, input ready);
   modport sink   (input valid, input byte_out, input segment, input segment_offset,
                   input pdu_end, input header_done, input opcode, input ahs_words,
                   input data_length, input task_tag, output ready);
endinterface

// ===== design/iscsi_pdu_deframer_core.sv =====
// An accepted byte's tagged word is registered and shows on rsp_bus in the cycle after the byte is accepted.
// Throughput: one byte per cycle; a byte is taken while the output register is
// empty or in the cycle the held word leaves, and the input stalls for as long
// as an unaccepted word waits.
// Reset (synchronous): segment tracking returns to basic header offset zero,
// captured header fields clear and the output register empties.
// ----------------------------------------------------------------------------
// iscsi_pdu_deframer_core
// Splits a received byte stream into iSCSI PDUs and tags every byte with its
// segment and offset; the last byte of a PDU carries the header fields.
// ----------------------------------------------------------------------------
module iscsi_pdu_deframer_core (
   input  logic           clock,
   input  logic           reset,
   ipdu_req_if.sink       req_bus,
   ipdu_rsp_if.source     rsp_bus
);

   ipdu_pkg::phase_type                phase_ff, phase_in;
   logic [ipdu_pkg::CountWidth-1:0]    count_ff, count_in;
   logic [ipdu_pkg::OpcodeWidth-1:0]   opcode_ff, opcode_in;
   logic [ipdu_pkg::ByteWidth-1:0]     ahs_ff, ahs_in;
   logic [ipdu_pkg::CountWidth-1:0]    dlen_ff, dlen_in;
   logic [ipdu_pkg::TagWidth-1:0]      tag_ff, tag_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ipdu_pkg::rsp_word_type             rsp_ff, rsp_in;

   ipdu_pkg::segment_type              seg;
   logic [ipdu_pkg::CountWidth-1:0]    seg_len;
   logic [ipdu_pkg::CountWidth:0]      count_inc;
   logic [1:0]                         pad_len;
   logic                               in_bhs;
   logic                               last;
   logic                               pdu_end;
   ipdu_pkg::phase_type                next_phase;
   logic                               accept;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      unique case (phase_ff)
         ipdu_pkg::PH_BHS:  seg = ipdu_pkg::SEG_BHS;
         ipdu_pkg::PH_AHS:  seg = ipdu_pkg::SEG_AHS;
         ipdu_pkg::PH_DATA: seg = ipdu_pkg::SEG_DATA;
         ipdu_pkg::PH_PAD:  seg = ipdu_pkg::SEG_PAD;
         default:           seg = ipdu_pkg::SEG_BHS;
      endcase
   end

   assign in_bhs = (phase_ff == ipdu_pkg::PH_BHS);

   // capture header fields as their bytes go past
   always_comb begin
      opcode_in = opcode_ff;
      ahs_in    = ahs_ff;
      dlen_in   = dlen_ff;
      tag_in    = tag_ff;
      if (in_bhs) begin
         if (count_ff == ipdu_pkg::HdrOpcodeIdx) begin
            opcode_in = req_bus.data_byte[ipdu_pkg::OpcodeWidth-1:0];
         end else if (count_ff == ipdu_pkg::HdrAhsIdx) begin
            ahs_in = req_bus.data_byte;
         end else if (count_ff >= ipdu_pkg::HdrDlenFirst && count_ff <= ipdu_pkg::HdrDlenLast) begin
            dlen_in = {dlen_ff[ipdu_pkg::CountWidth-ipdu_pkg::ByteWidth-1:0], req_bus.data_byte};
         end else if (count_ff >= ipdu_pkg::HdrTagFirst && count_ff <= ipdu_pkg::HdrTagLast) begin
            tag_in = {tag_ff[ipdu_pkg::TagWidth-ipdu_pkg::ByteWidth-1:0], req_bus.data_byte};
         end
      end
   end

   // padding rounds the data segment up to a whole word
   assign pad_len = 2'(3'd4 - {1'b0, dlen_in[1:0]});

   always_comb begin
      unique case (phase_ff)
         ipdu_pkg::PH_BHS:  seg_len = ipdu_pkg::HdrLength;
         ipdu_pkg::PH_AHS:  seg_len = {14'd0, ahs_in, 2'b00};
         ipdu_pkg::PH_DATA: seg_len = dlen_in;
         ipdu_pkg::PH_PAD:  seg_len = {22'd0, pad_len};
         default:           seg_len = ipdu_pkg::HdrLength;
      endcase
   end

   assign count_inc = {1'b0, count_ff} + 25'd1;
   assign last      = (seg_len == '0) || (count_inc >= {1'b0, seg_len});

   // pick the next non-empty segment, or close the PDU
   always_comb begin
      next_phase = ipdu_pkg::PH_BHS;
      pdu_end    = 1'b0;
      unique case (phase_ff)
         ipdu_pkg::PH_BHS: begin
            if (ahs_in != '0) begin
               next_phase = ipdu_pkg::PH_AHS;
            end else if (dlen_in != '0) begin
               next_phase = ipdu_pkg::PH_DATA;
            end else begin
               pdu_end = 1'b1;
            end
         end
         ipdu_pkg::PH_AHS: begin
            if (dlen_in != '0) begin
               next_phase = ipdu_pkg::PH_DATA;
            end else begin
               pdu_end = 1'b1;
            end
         end
         ipdu_pkg::PH_DATA: begin
            if (pad_len != '0) begin
               next_phase = ipdu_pkg::PH_PAD;
            end else begin
               pdu_end = 1'b1;
            end
         end
         ipdu_pkg::PH_PAD: begin
            pdu_end = 1'b1;
         end
         default: begin
            pdu_end = 1'b1;
         end
      endcase
      pdu_end = pdu_end && last;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            phase_in = next_phase;
            count_in = '0;
         end else begin
            count_in = count_inc[ipdu_pkg::CountWidth-1:0];
         end
      end
   end

   always_comb begin
      rsp_in.byte_out       = req_bus.data_byte;
      rsp_in.segment        = seg;
      rsp_in.segment_offset = count_ff;
      rsp_in.pdu_end        = pdu_end;
      rsp_in.header_done    = in_bhs && (count_ff == ipdu_pkg::HdrLastIdx);
      rsp_in.opcode         = pdu_end ? opcode_in : '0;
      rsp_in.ahs_words      = pdu_end ? ahs_in : '0;
      rsp_in.data_length    = pdu_end ? dlen_in : '0;
      rsp_in.task_tag       = pdu_end ? tag_in : '0;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ipdu_pkg::PH_BHS;
         count_ff     <= '0;
         opcode_ff    <= '0;
         ahs_ff       <= '0;
         dlen_ff      <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            opcode_ff <= opcode_in;
            ahs_ff    <= ahs_in;
            dlen_ff   <= dlen_in;
            tag_ff    <= tag_in;
         end
      end
   end

   // hold the word until taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.byte_out       = rsp_ff.byte_out;
   assign rsp_bus.segment        = rsp_ff.segment;
   assign rsp_bus.segment_offset = rsp_ff.segment_offset;
   assign rsp_bus.pdu_end        = rsp_ff.pdu_end;
   assign rsp_bus.header_done    = rsp_ff.header_done;
   assign rsp_bus.opcode         = rsp_ff.opcode;
   assign rsp_bus.ahs_words      = rsp_ff.ahs_words;
   assign rsp_bus.data_length    = rsp_ff.data_length;
   assign rsp_bus.task_tag       = rsp_ff.task_tag;

   a_bhs_end_on_last_hdr_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pdu_end && rsp_ff.segment == ipdu_pkg::SEG_BHS
      |-> rsp_ff.header_done)
      else $error("PDU closed inside basic header before its last byte");

   a_header_done_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.header_done
      |-> rsp_ff.segment == ipdu_pkg::SEG_BHS && rsp_ff.segment_offset == ipdu_pkg::HdrLastIdx)
      else $error("header_done on wrong byte");

   a_fields_zero_mid_pdu: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.pdu_end
      |-> rsp_ff.opcode == '0 && rsp_ff.ahs_words == '0 &&
          rsp_ff.data_length == '0 && rsp_ff.task_tag == '0)
      else $error("header fields shown before end of PDU");

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && pdu_end |=> phase_ff == ipdu_pkg::PH_BHS && count_ff == '0)
      else $error("next PDU does not start at basic header offset zero");

endmodule

// ===== dv/ipdu_frame_checker.sv =====
// ----------------------------------------------------------------------------
// ipdu_frame_checker
// Watches both channels of the PDU deframer, tracks the segment framing of
// the accepted byte stream and compares every tagged word with its prediction.
// ----------------------------------------------------------------------------
module ipdu_frame_checker (
   input  logic        clock,
   input  logic        reset,
   ipdu_req_if         req_mon,
   ipdu_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned words_pending
);

   ipdu_pkg::rsp_word_type          tagged_q[$];
   ipdu_pkg::rsp_word_type          want;
   ipdu_pkg::rsp_word_type          due;
   int unsigned                     mismatches = 0;

   // framing state as the block should hold it
   ipdu_pkg::segment_type           cur_seg;
   logic [ipdu_pkg::CountWidth-1:0] seg_pos;
   logic [5:0]                      hdr_opcode;
   logic [7:0]                      hdr_ahs;
   logic [23:0]                     hdr_dlen;
   logic [31:0]                     hdr_tag;

   logic [7:0]                      rx_byte;
   int unsigned                     seg_len;
   logic [1:0]                      pad_len;
   logic                            seg_last;
   logic                            pdu_over;
   ipdu_pkg::segment_type           nxt_seg;

   assign fail_count = mismatches;

   task automatic check_field(input string field, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tagged_q.delete();
         cur_seg    = ipdu_pkg::SEG_BHS;
         seg_pos    = '0;
         hdr_opcode = '0;
         hdr_ahs    = '0;
         hdr_dlen   = '0;
         hdr_tag    = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tagged_q.size() == 0) begin
               $error("word 0x%0h arrived with nothing outstanding", rsp_mon.byte_out);
               mismatches++;
            end else begin
               due = tagged_q.pop_front();
               check_field("byte_out", due.byte_out, rsp_mon.byte_out);
               check_field("segment", due.segment, rsp_mon.segment);
               check_field("segment_offset", due.segment_offset, rsp_mon.segment_offset);
               check_field("pdu_end", due.pdu_end, rsp_mon.pdu_end);
               check_field("header_done", due.header_done, rsp_mon.header_done);
               check_field("opcode", due.opcode, rsp_mon.opcode);
               check_field("ahs_words", due.ahs_words, rsp_mon.ahs_words);
               check_field("data_length", due.data_length, rsp_mon.data_length);
               check_field("task_tag", due.task_tag, rsp_mon.task_tag);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            rx_byte = req_mon.data_byte;
            // capture header fields as their bytes go past
            if (cur_seg == ipdu_pkg::SEG_BHS) begin
               if (seg_pos == ipdu_pkg::HdrOpcodeIdx)
                  hdr_opcode = rx_byte[5:0];
               else if (seg_pos == ipdu_pkg::HdrAhsIdx)
                  hdr_ahs = rx_byte;
               else if (seg_pos >= ipdu_pkg::HdrDlenFirst && seg_pos <= ipdu_pkg::HdrDlenLast)
                  hdr_dlen = {hdr_dlen[15:0], rx_byte};
               else if (seg_pos >= ipdu_pkg::HdrTagFirst && seg_pos <= ipdu_pkg::HdrTagLast)
                  hdr_tag = {hdr_tag[23:0], rx_byte};
            end

            pad_len = 2'd0 - hdr_dlen[1:0];
            case (cur_seg)
               ipdu_pkg::SEG_BHS:  seg_len = 32'(ipdu_pkg::HdrLength);
               ipdu_pkg::SEG_AHS:  seg_len = 32'({hdr_ahs, 2'b00});
               ipdu_pkg::SEG_DATA: seg_len = 32'(hdr_dlen);
               default:            seg_len = 32'(pad_len);
            endcase
            seg_last = (seg_len == 0) || (32'(seg_pos) + 32'd1 >= seg_len);

            // skip empty segments; the PDU ends when nothing follows
            pdu_over = 1'b0;
            nxt_seg  = ipdu_pkg::SEG_BHS;
            if (seg_last) begin
               if (cur_seg == ipdu_pkg::SEG_BHS && hdr_ahs != 0)
                  nxt_seg = ipdu_pkg::SEG_AHS;
               else if ((cur_seg == ipdu_pkg::SEG_BHS || cur_seg == ipdu_pkg::SEG_AHS) &&
                        hdr_dlen != 0)
                  nxt_seg = ipdu_pkg::SEG_DATA;
               else if (cur_seg == ipdu_pkg::SEG_DATA && pad_len != 0)
                  nxt_seg = ipdu_pkg::SEG_PAD;
               else
                  pdu_over = 1'b1;
            end

            want.byte_out       = rx_byte;
            want.segment        = cur_seg;
            want.segment_offset = seg_pos;
            want.pdu_end        = pdu_over;
            want.header_done    = (cur_seg == ipdu_pkg::SEG_BHS &&
                                   seg_pos == ipdu_pkg::HdrLastIdx);
            want.opcode         = pdu_over ? hdr_opcode : '0;
            want.ahs_words      = pdu_over ? hdr_ahs : '0;
            want.data_length    = pdu_over ? hdr_dlen : '0;
            want.task_tag       = pdu_over ? hdr_tag : '0;
            tagged_q.push_back(want);

            if (seg_last) begin
               cur_seg = nxt_seg;
               seg_pos = '0;
            end else begin
               seg_pos = seg_pos + 1'b1;
            end
         end
      end
      words_pending <= tagged_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds the PDU deframer with framed byte streams: directed PDUs covering
// empty, aligned and padded segments, then random PDUs, under idle and stall
// patterns that change along the stream, ending in a cut-off PDU with
// maximal lengths.
// ----------------------------------------------------------------------------
module testbench;

   typedef enum int {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   idle_mode_type idle_mode = IDLE_NONE;
   int            stall_order = 0;
   int unsigned   bytes_sent = 0;
   int unsigned   fail_count;
   int unsigned   words_pending;

   ipdu_req_if req_bus ();
   ipdu_rsp_if rsp_bus ();

   iscsi_pdu_deframer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ipdu_frame_checker frame_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always #10 clock = ~clock;

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls per mode, plus a long hold-off on request
   initial begin
      int stalls_done;
      int hold_left;
      stalls_done = 0;
      hold_left   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_order != stalls_done) begin
            stalls_done = stall_order;
            hold_left   = 64;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_mode == IDLE_RECV) begin
            rsp_bus.ready <= ($urandom_range(99) >= 55);
         end else if (idle_mode == IDLE_BOTH) begin
            rsp_bus.ready <= ($urandom_range(99) >= 36);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value);
      int unsigned pct;
      pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 36 : 0;
      while ($urandom_range(99) < pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // header fields at their offsets, every other byte random; cut shortens the PDU
   task automatic send_pdu(input logic [7:0] op_byte, input logic [7:0] ahs,
                           input logic [23:0] dlen, input logic [31:0] tag,
                           input int unsigned cut);
      int unsigned total;
      int unsigned stage;
      logic [1:0]  pad;
      logic [7:0]  value;
      // idle pattern follows progress through the stream
      stage = bytes_sent / 110;
      if (stage == 0)
         idle_mode <= IDLE_NONE;
      else if (stage == 1)
         idle_mode <= IDLE_SEND;
      else if (stage == 2)
         idle_mode <= IDLE_RECV;
      else
         idle_mode <= IDLE_BOTH;
      pad   = 2'd0 - dlen[1:0];
      total = ipdu_pkg::HdrLength + 4 * ahs + dlen + pad;
      if (cut != 0 && cut < total)
         total = cut;
      for (int unsigned i = 0; i < total; i++) begin
         value = 8'($urandom);
         if (i == ipdu_pkg::HdrOpcodeIdx)
            value = op_byte;
         else if (i == ipdu_pkg::HdrAhsIdx)
            value = ahs;
         else if (i >= ipdu_pkg::HdrDlenFirst && i <= ipdu_pkg::HdrDlenLast)
            value = dlen[8 * (ipdu_pkg::HdrDlenLast - i) +: 8];
         else if (i >= ipdu_pkg::HdrTagFirst && i <= ipdu_pkg::HdrTagLast)
            value = tag[8 * (ipdu_pkg::HdrTagLast - i) +: 8];
         send_byte(value);
      end
      bytes_sent += total;
   endtask

   initial begin
      int unsigned pick;
      logic [7:0]  ahs;
      logic [23:0] dlen;

      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // header-only PDUs with opcode and tag at both extremes
      send_pdu(8'h00, 8'd0, 24'd0, 32'h0000_0000, 0);
      send_pdu(8'hFF, 8'd0, 24'd0, 32'hFFFF_FFFF, 0);
      // additional header only, aligned data, then every padding length
      send_pdu(8'($urandom), 8'd1, 24'd0, $urandom, 0);
      send_pdu(8'($urandom), 8'd0, 24'd4, $urandom, 0);
      send_pdu(8'($urandom), 8'd0, 24'd1, $urandom, 0);
      send_pdu(8'($urandom), 8'd2, 24'd2, $urandom, 0);
      send_pdu(8'($urandom), 8'd1, 24'd3, $urandom, 0);

      // hold the receiver off while the stream keeps coming
      stall_order <= stall_order + 1;

      while (bytes_sent < 420) begin
         pick = $urandom_range(99);
         if (pick < 65)
            ahs = 8'd0;
         else if (pick < 95)
            ahs = 8'($urandom_range(4, 1));
         else
            ahs = 8'($urandom_range(16, 5));

         pick = $urandom_range(99);
         if (pick < 20)
            dlen = 24'd0;
         else if (pick < 92)
            dlen = 24'($urandom_range(64, 1));
         else
            dlen = 24'($urandom_range(128, 65));

         send_pdu(8'($urandom), ahs, dlen, $urandom, 0);
      end

      // maximal lengths, cut off inside the additional header
      send_pdu(8'($urandom), 8'hFF, 24'hFF_FFFF, $urandom, ipdu_pkg::HdrLength + 12);

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
